FILE: sv/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Types, fixed-point constants and small helpers shared by the HSL to RGB
// pipeline with terrain height shading. Fractions are Q.24 (1.0 = 2^24).
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  // fixed-point layout
  localparam int FRAC   = 24;          // fraction bits
  localparam int QW     = FRAC + 1;    // unsigned fraction, covers 0 .. just under 2.0
  localparam int SW     = FRAC + 4;    // signed working width for temporaries
  localparam int FW     = FRAC;        // hue ramp factor, always below 1.0
  localparam int EW     = QW + 3;      // room for six times a hue position
  localparam int PW     = SW + FW + 1; // signed ramp product
  localparam int NTERM  = 3;           // red, green, blue hue terms
  localparam int NSTAGE = 6;           // register stages from beat in to beat out

  localparam int TRUNC_BIAS = (1 << FRAC) - 1;

  localparam logic [QW-1:0] QONE        = QW'(64'd1 << FRAC);
  localparam logic [QW-1:0] QHALF       = QW'(64'd1 << (FRAC - 1));
  localparam logic [QW-1:0] QTHIRD      = QW'((64'd1 << FRAC) / 64'd3);
  localparam logic [QW-1:0] QTWO_THIRDS = QW'((64'd1 << (FRAC + 1)) / 64'd3);

  localparam logic signed [SW-1:0] QONE_S   = $signed(SW'(QONE));
  localparam logic signed [SW-1:0] QTHIRD_S = $signed(SW'(QTHIRD));

  // scale input x (0..239 range) to Q.24 by a reciprocal multiply:
  // floor(x * 2^24 / 239) == (x * ceil(2^40 / 239)) >> 16 for all 8-bit x
  localparam logic [63:0] SCALE_MAX = 64'd239;
  localparam int RSH = 16;
  localparam int RW  = 33;
  localparam int MW  = 8 + RW;
  localparam logic [RW-1:0] QRECIP =
    RW'(((64'd1 << (FRAC + RSH)) + SCALE_MAX - 64'd1) / SCALE_MAX);

  // opcodes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_SHADE   = 1'b1;

  // terrain shading
  localparam logic [7:0]  SHADE_HUE     = 8'd24;
  localparam logic [7:0]  SHADE_SAT     = 8'd224;
  localparam logic [7:0]  LUM_LOWLAND   = 8'd200;
  localparam logic [7:0]  LUM_PEAK      = 8'd40;
  localparam logic [7:0]  LUM_SLOPE     = 8'd178;
  localparam logic [15:0] HEIGHT_FLAT   = 16'd8;
  localparam logic [15:0] HEIGHT_TOP    = 16'd1023;
  localparam int          HEIGHT_SHIFT  = 3;
  localparam logic [7:0]  WATER_RED     = 8'd135;
  localparam logic [7:0]  WATER_GREEN   = 8'd155;
  localparam logic [7:0]  WATER_BLUE    = 8'd226;
  localparam logic [7:0]  CHAN_MAX      = 8'd255;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  hue;
    logic [7:0]  saturation;
    logic [7:0]  luminance;
    logic [15:0] land_height;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // scaled operands after stage 1
  typedef struct packed {
    logic [QW-1:0] hq;
    logic [QW-1:0] sq;
    logic [QW-1:0] lq;
    logic          water;
    logic          grey;
  } scaled_t;

  // result selection flags that ride along to the output stage
  typedef struct packed {
    logic       water;
    logic       grey;
    logic [7:0] grey_val;
  } side_t;

  // the two HSL temporaries and their difference
  typedef struct packed {
    logic signed [SW-1:0] t1;
    logic signed [SW-1:0] t2;
    logic signed [SW-1:0] d;
  } temps_t;

  // per-channel hue term: base select and ramp factor
  typedef struct packed {
    logic          use_t2;
    logic [FW-1:0] f;
  } hterm_t;

  // channel = trunc(v * 255 / 2^24), clamped to 0..255
  function automatic logic [7:0] to_channel(input logic signed [SW-1:0] v);
    logic [SW+7:0]      m;
    logic [SW+7-FRAC:0] c;
    m = {v, 8'd0} - {8'd0, v};
    c = m[SW+7:FRAC];
    if (v[SW-1]) begin
      return 8'd0;
    end else if (c > (SW+8-FRAC)'(CHAN_MAX)) begin
      return CHAN_MAX;
    end else begin
      return c[7:0];
    end
  endfunction

  // fold a hue position back into 0..1
  function automatic logic [QW-1:0] wrap_hue(input logic signed [SW-1:0] raw);
    logic signed [SW-1:0] t;
    if (raw[SW-1]) begin
      t = raw + QONE_S;
    end else if (raw > QONE_S) begin
      t = raw - QONE_S;
    end else begin
      t = raw;
    end
    return t[QW-1:0];
  endfunction

endpackage

FILE: sv/hsl_to_rgb_with_height_shading_top.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_with_height_shading_top
// HSL to 8-bit RGB converter with a terrain height shading mode.
//
// Usage:
//   pix channel (pix_valid/pix_ready/pix) carries one request beat: opcode 0
//   converts hue, saturation and luminance (0..239 scale); opcode 1 shades
//   land_height (zero gives water blue).
//   rgb channel (rgb_valid/rgb_ready/rgb) returns one colour beat per request,
//   in request order.
//   From pix acceptance to rgb_valid a beat passes six register stages:
//   scale, temporaries product, temporaries, ramp multiply, ramp add,
//   channel clamp.
//   Throughput is one beat per cycle with rgb_ready high; each stage holds
//   one beat and the ramp multipliers of the three lanes set the stage depth.
//   When rgb_ready is low, beats hold in place while bubbles ahead of them
//   close up; pix_ready drops only once all six stages are full.
//   Reset (rst, synchronous) empties the pipeline; no beat is in flight after.
// ----------------------------------------------------------------------------
module hsl_to_rgb_with_height_shading_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  hslrgb_pkg::pix_t  pix,
  output logic              rgb_valid,
  input  logic              rgb_ready,
  output hslrgb_pkg::rgb_t  rgb
);
  import hslrgb_pkg::*;

  logic [NSTAGE-1:0]    vld;
  logic [NSTAGE-1:0]    vld_in;
  logic [NSTAGE-1:0]    en;
  scaled_t              scaled;
  temps_t               temps;
  hterm_t [NTERM-1:0]   terms;
  side_t                side3;
  side_t                side4;
  side_t                side5;
  logic signed [SW-1:0] lane_v [NTERM];
  logic                 pix_fire;
  logic                 rgb_fire;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rgb_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in    = {vld[NSTAGE-2:0], pix_valid};
  assign pix_ready = en[0];
  assign rgb_valid = vld[NSTAGE-1];
  assign pix_fire  = pix_valid && pix_ready;
  assign rgb_fire  = rgb_valid && rgb_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  hslrgb_scale u_scale (
    .clk    (clk),
    .en     (en[0]),
    .pix    (pix),
    .scaled (scaled)
  );

  hslrgb_temps u_temps (
    .clk    (clk),
    .en     (en[2:1]),
    .scaled (scaled),
    .temps  (temps),
    .terms  (terms),
    .side   (side3)
  );

  for (genvar i = 0; i < NTERM; i++) begin : g_lane
    hslrgb_lane u_lane (
      .clk   (clk),
      .en    (en[4:3]),
      .temps (temps),
      .term  (terms[i]),
      .v     (lane_v[i])
    );
  end

  // side flags follow the lanes
  always_ff @(posedge clk) begin
    if (en[3]) begin
      side4 <= side3;
    end
    if (en[4]) begin
      side5 <= side4;
    end
  end

  // output stage: water, grey or converted channels
  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (side5.water) begin
        rgb.red   <= WATER_RED;
        rgb.green <= WATER_GREEN;
        rgb.blue  <= WATER_BLUE;
      end else if (side5.grey) begin
        rgb.red   <= side5.grey_val;
        rgb.green <= side5.grey_val;
        rgb.blue  <= side5.grey_val;
      end else begin
        rgb.red   <= to_channel(lane_v[0]);
        rgb.green <= to_channel(lane_v[1]);
        rgb.blue  <= to_channel(lane_v[2]);
      end
    end
  end

  // occupancy follows the handshakes
  a_fill: assert property (@(posedge clk) disable iff (rst)
    pix_fire && !rgb_fire |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("pipeline occupancy did not grow on accept");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !pix_fire && rgb_fire |=> $countones(vld) == $past($countones(vld)) - 1)
    else $error("pipeline occupancy did not shrink on delivery");

  a_steady: assert property (@(posedge clk) disable iff (rst)
    pix_fire == rgb_fire |=> $countones(vld) == $past($countones(vld)))
    else $error("pipeline occupancy changed without a handshake");

  a_room: assert property (@(posedge clk) disable iff (rst)
    !vld[NSTAGE-1] |-> pix_ready)
    else $error("input stalled with an empty output stage");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !rgb_ready |-> !pix_ready)
    else $error("input taken while pipeline full and stalled");

endmodule

FILE: sv/hslrgb_scale.sv
// ----------------------------------------------------------------------------
// hslrgb_scale
// Stage 1: picks the effective hue, saturation and luminance for the mode
// and scales each to Q.24 with a reciprocal multiply.
// ----------------------------------------------------------------------------
module hslrgb_scale (
  input  logic                clk,
  input  logic                en,
  input  hslrgb_pkg::pix_t    pix,
  output hslrgb_pkg::scaled_t scaled
);
  import hslrgb_pkg::*;

  logic [7:0]    shade_lum;
  logic [7:0]    hue_x;
  logic [7:0]    sat_x;
  logic [7:0]    lum_x;
  logic [MW-1:0] hue_p;
  logic [MW-1:0] sat_p;
  logic [MW-1:0] lum_p;

  // luminance from terrain height
  always_comb begin
    if (pix.land_height < HEIGHT_FLAT) begin
      shade_lum = LUM_LOWLAND;
    end else if (pix.land_height > HEIGHT_TOP) begin
      shade_lum = LUM_PEAK;
    end else begin
      shade_lum = LUM_SLOPE - 8'(pix.land_height >> HEIGHT_SHIFT);
    end
  end

  // operand select per mode
  always_comb begin
    if (pix.opcode == OP_SHADE) begin
      hue_x = SHADE_HUE;
      sat_x = SHADE_SAT;
      lum_x = shade_lum;
    end else begin
      hue_x = pix.hue;
      sat_x = pix.saturation;
      lum_x = pix.luminance;
    end
  end

  // divide by 239 through the reciprocal
  assign hue_p = MW'(hue_x) * MW'(QRECIP);
  assign sat_p = MW'(sat_x) * MW'(QRECIP);
  assign lum_p = MW'(lum_x) * MW'(QRECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      scaled.hq    <= hue_p[RSH+QW-1:RSH];
      scaled.sq    <= sat_p[RSH+QW-1:RSH];
      scaled.lq    <= lum_p[RSH+QW-1:RSH];
      scaled.water <= (pix.opcode == OP_SHADE) && (pix.land_height == '0);
      scaled.grey  <= (sat_x == '0);
    end
  end

endmodule

FILE: sv/hslrgb_temps.sv
// ----------------------------------------------------------------------------
// hslrgb_temps
// Stages 2 and 3: forms the two HSL temporaries and, for each channel,
// classifies the wrapped hue position into a base and a ramp factor.
// ----------------------------------------------------------------------------
module hslrgb_temps (
  input  logic                                     clk,
  input  logic [1:0]                               en,
  input  hslrgb_pkg::scaled_t                      scaled,
  output hslrgb_pkg::temps_t                       temps,
  output hslrgb_pkg::hterm_t [hslrgb_pkg::NTERM-1:0] terms,
  output hslrgb_pkg::side_t                        side
);
  import hslrgb_pkg::*;

  // stage 2 combinational
  logic                 lo;
  logic [QW:0]          mul_b;
  logic [2*QW:0]        prod;
  logic signed [SW-1:0] hq_s;
  logic [QW-1:0]        tw_next [NTERM];

  // stage 2 registers
  logic [QW:0]   pq;
  logic          lo_r;
  logic [QW-1:0] lq_r;
  logic [QW-1:0] sq_r;
  logic [QW-1:0] tw [NTERM];
  side_t         side_r;

  // stage 3 combinational
  logic signed [SW-1:0] lq_s;
  logic signed [SW-1:0] sq_s;
  logic signed [SW-1:0] pq_s;
  temps_t               temps_next;
  logic [EW-1:0]        t6 [NTERM];
  logic [EW-1:0]        t2x [NTERM];
  logic [EW-1:0]        t3 [NTERM];
  logic [EW-1:0]        r6 [NTERM];
  logic [QW-1:0]        rem [NTERM];
  hterm_t               term_next [NTERM];

  // l * (1 + s) below half luminance, l * s otherwise
  assign lo    = scaled.lq < QHALF;
  assign mul_b = lo ? ({1'b0, QONE} + {1'b0, scaled.sq}) : {1'b0, scaled.sq};
  assign prod  = (2*QW+1)'(scaled.lq) * (2*QW+1)'(mul_b);
  assign hq_s  = $signed(SW'(scaled.hq));

  // hue positions for red, green, blue, wrapped into 0..1
  assign tw_next[0] = wrap_hue(hq_s + QTHIRD_S);
  assign tw_next[1] = wrap_hue(hq_s);
  assign tw_next[2] = wrap_hue(hq_s - QTHIRD_S);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pq              <= prod[FRAC+QW:FRAC];
      lo_r            <= lo;
      lq_r            <= scaled.lq;
      sq_r            <= scaled.sq;
      tw              <= tw_next;
      side_r.water    <= scaled.water;
      side_r.grey     <= scaled.grey;
      side_r.grey_val <= to_channel($signed(SW'(scaled.lq)));
    end
  end

  // temporaries
  assign lq_s = $signed(SW'(lq_r));
  assign sq_s = $signed(SW'(sq_r));
  assign pq_s = $signed(SW'(pq));

  always_comb begin
    temps_next.t2 = lo_r ? pq_s : (lq_s + sq_s - pq_s);
    temps_next.t1 = (lq_s <<< 1) - temps_next.t2;
    temps_next.d  = temps_next.t2 - temps_next.t1;
  end

  // hue segment: rising ramp, flat at t2, falling ramp, flat at t1
  always_comb begin
    for (int i = 0; i < NTERM; i++) begin
      t6[i]  = EW'(tw[i]) * EW'(6);
      t2x[i] = EW'(tw[i]) << 1;
      t3[i]  = EW'(tw[i]) * EW'(3);
      rem[i] = QTWO_THIRDS - tw[i];
      r6[i]  = EW'(rem[i]) * EW'(6);
      term_next[i].use_t2 = (t6[i] >= EW'(QONE)) && (t2x[i] < EW'(QONE));
      if (t6[i] < EW'(QONE)) begin
        term_next[i].f = t6[i][FW-1:0];
      end else if ((t2x[i] >= EW'(QONE)) && (t3[i] < (EW'(QONE) << 1))) begin
        term_next[i].f = r6[i][FW-1:0];
      end else begin
        term_next[i].f = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      temps <= temps_next;
      side  <= side_r;
      for (int i = 0; i < NTERM; i++) begin
        terms[i] <= term_next[i];
      end
    end
  end

endmodule

FILE: sv/hslrgb_lane.sv
// ----------------------------------------------------------------------------
// hslrgb_lane
// Stages 4 and 5 of one colour channel: ramp multiply, then truncation
// toward zero and the add onto the base temporary.
// ----------------------------------------------------------------------------
module hslrgb_lane (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  hslrgb_pkg::temps_t                  temps,
  input  hslrgb_pkg::hterm_t                  term,
  output logic signed [hslrgb_pkg::SW-1:0]    v
);
  import hslrgb_pkg::*;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] base_r;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] quot;

  // d times the ramp factor
  assign prod = PW'(temps.d) * PW'($signed({1'b0, term.f}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod;
      base_r <= term.use_t2 ? temps.t2 : temps.t1;
    end
  end

  // scale back by 2^24, rounding toward zero
  assign bias = prod_r[PW-1] ? PW'(TRUNC_BIAS) : '0;
  assign quot = (prod_r + bias) >>> FRAC;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v <= base_r + SW'(quot);
    end
  end

endmodule
